// ----- rtl/core/mpd_pkg.sv -----
// Shared types and codes for the mesh packet deframer.
package mpd_pkg;

  localparam int MAX_PAYLOAD_DEF = 65535;

  // field kinds, also used as parser phase codes
  localparam logic [3:0] PH_VERSION = 4'd0;
  localparam logic [3:0] PH_TYPE    = 4'd1;
  localparam logic [3:0] PH_TTL     = 4'd2;
  localparam logic [3:0] PH_TIME    = 4'd3;
  localparam logic [3:0] PH_FLAGS   = 4'd4;
  localparam logic [3:0] PH_LENGTH  = 4'd5;
  localparam logic [3:0] PH_SENDER  = 4'd6;
  localparam logic [3:0] PH_RECIP   = 4'd7;
  localparam logic [3:0] PH_RCOUNT  = 4'd8;
  localparam logic [3:0] PH_ROUTE   = 4'd9;
  localparam logic [3:0] PH_PAYLOAD = 4'd10;
  localparam logic [3:0] PH_SIG     = 4'd11;
  localparam logic [3:0] PH_PAD     = 4'd12;
  localparam logic [3:0] PH_DISCARD = 4'd13;

  localparam logic [3:0] ST_BUSY       = 4'd0;
  localparam logic [3:0] ST_OK         = 4'd1;
  localparam logic [3:0] ST_HEADER     = 4'd2;
  localparam logic [3:0] ST_SENDER     = 4'd3;
  localparam logic [3:0] ST_RECIP      = 4'd4;
  localparam logic [3:0] ST_ROUTE      = 4'd5;
  localparam logic [3:0] ST_SHORT      = 4'd6;
  localparam logic [3:0] ST_COMPRESSED = 4'd7;
  localparam logic [3:0] ST_SIGNATURE  = 4'd8;
  localparam logic [3:0] ST_PADDING    = 4'd9;

  // flag byte bits
  localparam int FL_RECIP = 0;
  localparam int FL_SIG   = 1;
  localparam int FL_COMPR = 2;
  localparam int FL_ROUTE = 3;
  localparam int FL_RSR   = 4;

  localparam logic [7:0] VER_1 = 8'd1;
  localparam logic [7:0] VER_2 = 8'd2;

  localparam int SIG_BYTES = 64;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [7:0]  data_byte;
    logic [15:0] field_offset;
    logic        frame_end;
    logic [3:0]  status;
    logic [7:0]  msg_version;
    logic [7:0]  msg_type;
    logic [7:0]  hop_ttl;
    logic [63:0] time_stamp;
    logic [15:0] payload_length;
    logic [5:0]  flag_bits;
  } out_t;

endpackage

// ----- rtl/core/mpd_parser.sv -----
// Frame field state machine: tags one word and updates the parse state.
module mpd_parser
  import mpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  item,
  output out_t res
);

  logic [3:0]  phase, phase_next;
  logic [15:0] cnt, cnt_next;
  logic [7:0]  ver, ver_next;
  logic [7:0]  mtype, mtype_next;
  logic [7:0]  ttl, ttl_next;
  logic [63:0] tstamp, tstamp_next;
  logic [4:0]  flags, flags_next;
  logic [16:0] length, length_next;
  logic [10:0] route_rem, route_rem_next;
  logic        orig_nz, orig_nz_next;
  logic [7:0]  pad_value, pad_value_next;
  logic [8:0]  pad_count, pad_count_next;
  logic        pad_mismatch, pad_mismatch_next;
  logic [3:0]  err, err_next;

  logic [7:0]  b;
  logic [15:0] cnt_inc;
  logic [16:0] cnt_plus1;
  logic [23:0] len_shift;
  logic [16:0] len_need;
  logic [10:0] rr_dec;
  logic        ap_bad;
  logic [3:0]  ap_phase, ep_phase, ar_phase, as_phase;
  logic [3:0]  end_status;
  logic        v2;

  assign b         = item.frame_byte;
  assign cnt_inc   = (cnt == 16'hFFFF) ? cnt : cnt + 16'd1;
  assign cnt_plus1 = {1'b0, cnt} + 17'd1;
  assign len_shift = {length[15:0], b};
  assign rr_dec    = (route_rem != 11'd0) ? route_rem - 11'd1 : route_rem;
  assign len_need  = (ver == VER_1) ? 17'd2 : 17'd4;

  // transition chain after the sender id; discard is only reached by a bad compressed payload
  assign ap_bad   = (ver == VER_1) && flags[FL_COMPR] && ((length <= 17'd2) || !orig_nz_next);
  assign ap_phase = ap_bad ? PH_DISCARD : (flags[FL_SIG] ? PH_SIG : PH_PAD);
  assign ep_phase = (length == 17'd0) ? ap_phase : PH_PAYLOAD;
  assign ar_phase = ((ver == VER_2) && flags[FL_ROUTE]) ? PH_RCOUNT : ep_phase;
  assign as_phase = flags[FL_RECIP] ? PH_RECIP : ar_phase;

  always_comb begin
    phase_next        = phase;
    cnt_next          = cnt;
    ver_next          = ver;
    mtype_next        = mtype;
    ttl_next          = ttl;
    tstamp_next       = tstamp;
    flags_next        = flags;
    length_next       = length;
    route_rem_next    = route_rem;
    orig_nz_next      = orig_nz;
    pad_value_next    = pad_value;
    pad_count_next    = pad_count;
    pad_mismatch_next = pad_mismatch;
    err_next          = err;
    if (phase == PH_PAYLOAD) begin
      if (cnt == 16'd0) begin
        orig_nz_next = (b != 8'd0);
      end else if (cnt == 16'd1) begin
        orig_nz_next = orig_nz || (b != 8'd0);
      end
    end
    unique case (phase)
      PH_VERSION: begin
        ver_next = b;
        cnt_next = '0;
        if (b != VER_1 && b != VER_2) begin
          phase_next = PH_DISCARD;
          err_next   = ST_HEADER;
        end else begin
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        mtype_next = b;
        phase_next = PH_TTL;
        cnt_next   = '0;
      end
      PH_TTL: begin
        ttl_next   = b;
        phase_next = PH_TIME;
        cnt_next   = '0;
      end
      PH_TIME: begin
        tstamp_next = {tstamp[55:0], b};
        if (cnt >= 16'd7) begin
          phase_next = PH_FLAGS;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_FLAGS: begin
        flags_next = b[4:0];
        phase_next = PH_LENGTH;
        cnt_next   = '0;
      end
      PH_LENGTH: begin
        if (!length[16]) begin
          length_next = (len_shift[23:16] != 8'd0) ? 17'h10000 : {1'b0, len_shift[15:0]};
        end
        if (cnt_plus1 >= len_need) begin
          cnt_next = '0;
          if (length_next > 17'(MAX_PAYLOAD)) begin
            phase_next = PH_DISCARD;
            err_next   = ST_HEADER;
          end else begin
            phase_next = PH_SENDER;
          end
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_SENDER: begin
        if (cnt >= 16'd7) begin
          phase_next = as_phase;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_RECIP: begin
        if (cnt >= 16'd7) begin
          phase_next = ar_phase;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_RCOUNT: begin
        route_rem_next = {b, 3'b000};
        cnt_next       = '0;
        phase_next     = (b == 8'd0) ? ep_phase : PH_ROUTE;
      end
      PH_ROUTE: begin
        route_rem_next = rr_dec;
        if (rr_dec == 11'd0) begin
          phase_next = ep_phase;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_PAYLOAD: begin
        if (cnt_plus1 >= length) begin
          phase_next = ap_phase;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_SIG: begin
        if (cnt >= 16'(SIG_BYTES - 1)) begin
          phase_next = PH_PAD;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt_inc;
        end
      end
      PH_PAD: begin
        if (pad_count == 9'd0) begin
          pad_value_next = b;
        end else if (b != pad_value) begin
          pad_mismatch_next = 1'b1;
        end
        if (pad_count < 9'd256) begin
          pad_count_next = pad_count + 9'd1;
        end
        cnt_next = cnt_inc;
      end
      default: begin
        phase_next = PH_DISCARD;
        cnt_next   = cnt_inc;
      end
    endcase
    // a chain that lands in discard did so on a bad compressed payload
    if (phase_next == PH_DISCARD && err_next == ST_BUSY) begin
      err_next = ST_COMPRESSED;
    end
  end

  always_comb begin
    if (err_next != ST_BUSY) begin
      end_status = err_next;
    end else begin
      unique case (phase_next)
        PH_SENDER:           end_status = ST_SENDER;
        PH_RECIP:            end_status = ST_RECIP;
        PH_RCOUNT, PH_ROUTE: end_status = ST_ROUTE;
        PH_PAYLOAD:          end_status = ST_SHORT;
        PH_SIG:              end_status = ST_SIGNATURE;
        PH_PAD: begin
          if (pad_count_next == 9'd0) begin
            end_status = ST_OK;
          end else if (pad_value_next == 8'd0 || pad_mismatch_next ||
                       pad_count_next != {1'b0, pad_value_next}) begin
            end_status = ST_PADDING;
          end else begin
            end_status = ST_OK;
          end
        end
        default:             end_status = ST_HEADER;
      endcase
    end
  end

  assign v2 = (ver_next == VER_2);

  always_comb begin
    res              = '0;
    res.field_kind   = (phase > PH_DISCARD) ? PH_DISCARD : phase;
    res.data_byte    = b;
    res.field_offset = cnt;
    res.frame_end    = item.last_byte;
    if (item.last_byte) begin
      res.status         = end_status;
      res.msg_version    = ver_next;
      res.msg_type       = mtype_next;
      res.hop_ttl        = ttl_next;
      res.time_stamp     = tstamp_next;
      res.payload_length = length_next[16] ? 16'hFFFF : length_next[15:0];
      res.flag_bits      = {v2 && flags_next[FL_ROUTE], v2, flags_next[FL_RSR],
                            flags_next[FL_COMPR:FL_RECIP]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.last_byte)) begin
      phase        <= PH_VERSION;
      cnt          <= '0;
      ver          <= '0;
      mtype        <= '0;
      ttl          <= '0;
      tstamp       <= '0;
      flags        <= '0;
      length       <= '0;
      route_rem    <= '0;
      orig_nz      <= 1'b0;
      pad_value    <= '0;
      pad_count    <= '0;
      pad_mismatch <= 1'b0;
      err          <= ST_BUSY;
    end else if (step) begin
      phase        <= phase_next;
      cnt          <= cnt_next;
      ver          <= ver_next;
      mtype        <= mtype_next;
      ttl          <= ttl_next;
      tstamp       <= tstamp_next;
      flags        <= flags_next;
      length       <= length_next;
      route_rem    <= route_rem_next;
      orig_nz      <= orig_nz_next;
      pad_value    <= pad_value_next;
      pad_count    <= pad_count_next;
      pad_mismatch <= pad_mismatch_next;
      err          <= err_next;
    end
  end

  a_frame_restart: assert property (@(posedge clk) disable iff (rst)
    step && item.last_byte |=> phase == PH_VERSION && cnt == 16'd0 && err == ST_BUSY)
    else $error("parser state not cleared after frame end");

  a_err_discards: assert property (@(posedge clk) disable iff (rst)
    err != ST_BUSY |-> phase == PH_DISCARD)
    else $error("error latched outside discard phase");

  a_pad_bounded: assert property (@(posedge clk) disable iff (rst)
    pad_count <= 9'd256)
    else $error("pad count ran past saturation");

  a_route_phase: assert property (@(posedge clk) disable iff (rst)
    phase == PH_ROUTE |-> route_rem != 11'd0)
    else $error("route phase with nothing left");

endmodule

// ----- rtl/core/mesh_packet_deframer_core.sv -----
// Mesh packet deframer top level: input register, field parser, result register.
//
// Input channel in_valid/in_ready/in_data carries one frame word per transfer:
// the raw byte and a mark on the last byte of the frame. The output channel
// out_valid/out_ready/out_data returns exactly one result per input word: the
// byte with its field tag and offset, and on the last word the frame status
// and the decoded header (zero on all other words).
// A word taken in sits in the input register, passes the combinational parser
// and is captured in the result register as the parser state advances. The
// core takes one word per cycle while the receiver does not stall; the parser
// update is a single pass of compares and small adds on the field counter.
// If the receiver stalls, the result register holds its word and the input
// register takes one more word, after which in_ready drops until out_ready
// returns. Reset (rst, synchronous) empties both registers and puts the
// parser at the version byte of a new frame; every frame end does the same
// for the parser.
module mesh_packet_deframer_core
  import mpd_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic in_full;
  in_t  in_hold;
  logic advance;
  out_t res;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_hold <= in_data;
    end
  end

  mpd_parser #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_parser (
    .clk (clk),
    .rst (rst),
    .step(advance),
    .item(in_hold),
    .res (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= advance;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= res;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_full && out_valid && !out_ready)
    else $error("input blocked without a stalled result");

  a_end_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_end |-> out_data.status != ST_BUSY)
    else $error("frame end reported without a status");

  a_mid_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.frame_end |-> out_data.status == ST_BUSY)
    else $error("status reported before frame end");

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.field_kind <= PH_DISCARD)
    else $error("field tag out of range");

endmodule

// ----- dv/tb_mesh_packet_deframer_core.sv -----
// Testbench for mesh_packet_deframer_core: random frames against a byte-level field predictor.
`timescale 1ns / 1ps

module tb_mesh_packet_deframer_core;
  import mpd_pkg::*;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  mesh_packet_deframer_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  in_t  rx_bytes_q[$];     // words waiting to be sent
  out_t tag_results_q[$];  // predicted field tags for accepted words

  int bytes_fed = 0;
  int bytes_queued = 0;
  int frames_queued = 0;
  int tags_checked = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int status_seen[16];

  // predictor state
  logic [3:0]  st_phase;
  logic [15:0] st_cnt;
  logic [7:0]  st_ver, st_type, st_ttl, st_flags;
  logic [63:0] st_ts;
  logic [16:0] st_len;
  logic [10:0] st_route;
  logic [15:0] st_orig;
  logic [7:0]  st_pad_val;
  logic [8:0]  st_pad_cnt;
  logic        st_pad_bad;
  logic [3:0]  st_err;

  function automatic void dfr_clear();
    st_phase = PH_VERSION;
    st_cnt = '0;
    st_ver = '0;
    st_type = '0;
    st_ttl = '0;
    st_flags = '0;
    st_ts = '0;
    st_len = '0;
    st_route = '0;
    st_orig = '0;
    st_pad_val = '0;
    st_pad_cnt = '0;
    st_pad_bad = 1'b0;
    st_err = ST_BUSY;
  endfunction

  function automatic void dfr_goto(input logic [3:0] p);
    st_phase = p;
    st_cnt = '0;
  endfunction

  function automatic void dfr_fail(input logic [3:0] code);
    st_err = code;
    dfr_goto(PH_DISCARD);
  endfunction

  function automatic void dfr_count();
    if (st_cnt != 16'hFFFF) st_cnt = st_cnt + 16'd1;
  endfunction

  function automatic void dfr_after_payload();
    if (st_ver == VER_1 && st_flags[FL_COMPR] && (st_len <= 2 || st_orig == 0))
      dfr_fail(ST_COMPRESSED);
    else if (st_flags[FL_SIG])
      dfr_goto(PH_SIG);
    else
      dfr_goto(PH_PAD);
  endfunction

  function automatic void dfr_enter_payload();
    if (st_len == 0) dfr_after_payload();
    else dfr_goto(PH_PAYLOAD);
  endfunction

  function automatic void dfr_after_recip();
    if (st_ver == VER_2 && st_flags[FL_ROUTE]) dfr_goto(PH_RCOUNT);
    else dfr_enter_payload();
  endfunction

  function automatic logic [3:0] dfr_end_status();
    if (st_err != ST_BUSY) return st_err;
    case (st_phase)
      PH_SENDER:           return ST_SENDER;
      PH_RECIP:            return ST_RECIP;
      PH_RCOUNT, PH_ROUTE: return ST_ROUTE;
      PH_PAYLOAD:          return ST_SHORT;
      PH_SIG:              return ST_SIGNATURE;
      PH_PAD: begin
        if (st_pad_cnt == 0) return ST_OK;
        if (st_pad_val == 0 || st_pad_bad || st_pad_cnt != {1'b0, st_pad_val})
          return ST_PADDING;
        return ST_OK;
      end
      default:             return ST_HEADER;
    endcase
  endfunction

  // Tags one frame byte and advances the field walk.
  function automatic out_t deframe_word(input in_t w);
    logic [7:0]  b;
    logic [3:0]  kind;
    logic [15:0] off;
    logic [31:0] acc;
    out_t r;
    b = w.frame_byte;
    kind = (st_phase > PH_DISCARD) ? PH_DISCARD : st_phase;
    off = st_cnt;
    case (st_phase)
      PH_VERSION: begin
        st_ver = b;
        if (b != VER_1 && b != VER_2) dfr_fail(ST_HEADER);
        else dfr_goto(PH_TYPE);
      end
      PH_TYPE: begin
        st_type = b;
        dfr_goto(PH_TTL);
      end
      PH_TTL: begin
        st_ttl = b;
        dfr_goto(PH_TIME);
      end
      PH_TIME: begin
        st_ts = {st_ts[55:0], b};
        if (st_cnt >= 7) dfr_goto(PH_FLAGS);
        else dfr_count();
      end
      PH_FLAGS: begin
        st_flags = b;
        dfr_goto(PH_LENGTH);
      end
      PH_LENGTH: begin
        if (st_len < 17'h10000) begin
          acc = (32'(st_len) << 8) | 32'(b);
          st_len = (acc > 32'hFFFF) ? 17'h10000 : acc[16:0];
        end
        if (32'(st_cnt) + 1 >= ((st_ver == VER_1) ? 32'd2 : 32'd4)) begin
          if (st_len > MAX_PAYLOAD_DEF) dfr_fail(ST_HEADER);
          else dfr_goto(PH_SENDER);
        end else begin
          dfr_count();
        end
      end
      PH_SENDER: begin
        if (st_cnt >= 7) begin
          if (st_flags[FL_RECIP]) dfr_goto(PH_RECIP);
          else dfr_after_recip();
        end else begin
          dfr_count();
        end
      end
      PH_RECIP: begin
        if (st_cnt >= 7) dfr_after_recip();
        else dfr_count();
      end
      PH_RCOUNT: begin
        st_route = {b, 3'b000};
        if (st_route == 0) dfr_enter_payload();
        else dfr_goto(PH_ROUTE);
      end
      PH_ROUTE: begin
        if (st_route > 0) st_route = st_route - 11'd1;
        if (st_route == 0) dfr_enter_payload();
        else dfr_count();
      end
      PH_PAYLOAD: begin
        if (st_cnt == 0) st_orig = {b, 8'h00};
        else if (st_cnt == 1) st_orig[7:0] = b;
        if (32'(st_cnt) + 1 >= 32'(st_len)) dfr_after_payload();
        else dfr_count();
      end
      PH_SIG: begin
        if (st_cnt >= SIG_BYTES - 1) dfr_goto(PH_PAD);
        else dfr_count();
      end
      PH_PAD: begin
        if (st_pad_cnt == 0) st_pad_val = b;
        else if (b != st_pad_val) st_pad_bad = 1'b1;
        if (st_pad_cnt < 256) st_pad_cnt = st_pad_cnt + 9'd1;
        dfr_count();
      end
      default: begin
        st_phase = PH_DISCARD;
        dfr_count();
      end
    endcase
    r = '0;
    r.field_kind = kind;
    r.data_byte = b;
    r.field_offset = off;
    r.frame_end = w.last_byte;
    if (w.last_byte) begin
      r.status = dfr_end_status();
      r.msg_version = st_ver;
      r.msg_type = st_type;
      r.hop_ttl = st_ttl;
      r.time_stamp = st_ts;
      r.payload_length = (st_len > 17'hFFFF) ? 16'hFFFF : st_len[15:0];
      r.flag_bits = {st_ver == VER_2 && st_flags[FL_ROUTE], st_ver == VER_2,
                     st_flags[FL_RSR], st_flags[2:0]};
      dfr_clear();
    end
    return r;
  endfunction

  task automatic push_word(input logic [7:0] b, input logic last);
    in_t w;
    w.frame_byte = b;
    w.last_byte = last;
    rx_bytes_q.push_back(w);
    bytes_queued++;
    if (last) frames_queued++;
  endtask

  // Builds one frame: mostly well formed, some cut short, some noise.
  task automatic gen_frame();
    logic [7:0] f[$];
    logic [7:0] ver, flags, pval;
    int plen, nroute, npad, cut, k, shape, idx;
    bit zero_orig;
    f = {};
    if ($urandom_range(0, 19) == 0) begin
      k = $urandom_range(1, 12);
      repeat (k) f.push_back(8'($urandom));
    end else begin
      k = $urandom_range(0, 19);
      ver = (k == 0) ? 8'($urandom) : (k < 10) ? VER_1 : VER_2;
      f.push_back(ver);
      repeat (10) f.push_back(8'($urandom));  // type, ttl, timestamp
      flags = 8'($urandom);
      flags[FL_SIG] = ($urandom_range(0, 5) == 0);
      f.push_back(flags);
      k = $urandom_range(0, 19);
      plen = (k == 0) ? $urandom_range(40, 300) :
             (k < 4) ? $urandom_range(0, 3) : $urandom_range(0, 24);
      if (ver == VER_2) begin
        if ($urandom_range(0, 14) == 0) begin
          f.push_back(8'($urandom_range(1, 255)));
          f.push_back(8'($urandom));
        end else begin
          f.push_back(8'h00);
          f.push_back(8'h00);
        end
      end
      f.push_back(8'(plen >> 8));
      f.push_back(8'(plen));
      repeat (8) f.push_back(8'($urandom));  // sender
      if (flags[FL_RECIP]) repeat (8) f.push_back(8'($urandom));
      if (ver == VER_2 && flags[FL_ROUTE]) begin
        nroute = $urandom_range(0, 3);
        f.push_back(8'(nroute));
        repeat (nroute * 8) f.push_back(8'($urandom));
      end
      zero_orig = ($urandom_range(0, 2) == 0);
      for (k = 0; k < plen; k++)
        f.push_back((k < 2 && zero_orig) ? 8'h00 : 8'($urandom));
      if (flags[FL_SIG]) repeat (SIG_BYTES) f.push_back(8'($urandom));
      shape = $urandom_range(0, 9);
      npad = 0;
      pval = '0;
      if (shape >= 1 && shape <= 5) begin
        npad = $urandom_range(1, 16);
        pval = 8'(npad);
      end else if (shape == 6) begin
        npad = $urandom_range(1, 4);
      end else if (shape == 7 || shape == 8) begin
        npad = $urandom_range(2, 16);
        pval = (shape == 8) ? 8'(npad + 1) : 8'(npad);
      end else if (shape == 9) begin
        npad = ($urandom_range(0, 3) == 0) ? $urandom_range(250, 262) : $urandom_range(1, 16);
        pval = 8'($urandom);
      end
      repeat (npad) f.push_back(pval);
      if (shape == 7) begin
        idx = f.size() - 1 - $urandom_range(0, npad - 1);
        f[idx] = pval + 8'd1;
      end
      if ($urandom_range(0, 3) == 0) begin
        cut = $urandom_range(1, f.size());
        while (f.size() > cut) void'(f.pop_back());
      end
    end
    for (k = 0; k < f.size(); k++) push_word(f[k], k == f.size() - 1);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result %0d %s: expected %0h, got %0h", tags_checked, name, want, got);
    end
  endtask

  // sender: bursts of words with random gaps
  always @(posedge clk) begin : drive
    logic nv;
    in_t  nd;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      nv = in_valid;
      nd = in_data;
      if (in_valid && in_ready) begin
        tag_results_q.push_back(deframe_word(in_data));
        bytes_fed++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (rx_bytes_q.size() > 0) begin
          nv = 1'b1;
          nd = rx_bytes_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      in_valid <= nv;
      in_data <= nd;
    end
  end

  // receiver: checks results and stalls in modes that change now and then
  always @(posedge clk) begin : watch
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (tag_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte %0h kind %0d", out_data.data_byte,
                   out_data.field_kind);
      end else begin
        want = tag_results_q.pop_front();
        check_field("field_kind", want.field_kind, out_data.field_kind);
        check_field("data_byte", want.data_byte, out_data.data_byte);
        check_field("field_offset", want.field_offset, out_data.field_offset);
        check_field("frame_end", want.frame_end, out_data.frame_end);
        check_field("status", want.status, out_data.status);
        check_field("msg_version", want.msg_version, out_data.msg_version);
        check_field("msg_type", want.msg_type, out_data.msg_type);
        check_field("hop_ttl", want.hop_ttl, out_data.hop_ttl);
        check_field("time_stamp", want.time_stamp, out_data.time_stamp);
        check_field("payload_length", want.payload_length, out_data.payload_length);
        check_field("flag_bits", want.flag_bits, out_data.flag_bits);
        if (want.frame_end) status_seen[want.status]++;
        tags_checked++;
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(10, 150);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      2:       out_ready <= ($urandom_range(0, 1) == 1);
      3:       out_ready <= ($urandom_range(0, 4) == 0);
      default: out_ready <= 1'b1;
    endcase
  end

  initial begin
    int k;
    dfr_clear();
    foreach (status_seen[k]) status_seen[k] = 0;
    // bad version bytes, a cut header, an oversized v2 length
    push_word(8'h00, 1'b1);
    push_word(8'hFF, 1'b0);
    push_word(8'h5A, 1'b1);
    push_word(VER_1, 1'b0);
    push_word(8'hA5, 1'b1);
    push_word(VER_2, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    repeat (8) push_word(8'hFF, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h01, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h00, 1'b0);
    push_word(8'h3C, 1'b1);
    k = bytes_queued;
    while (bytes_queued < k + 550) gen_frame();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    while (rx_bytes_q.size() != 0 || in_valid || tag_results_q.size() != 0)
      @(posedge clk);
    repeat (12) @(posedge clk);

    $display("%0d bytes in %0d frames fed, %0d results checked", bytes_fed,
             frames_queued, tags_checked);
    $display("end status counts ok %0d hdr %0d snd %0d rcp %0d rte %0d short %0d",
             status_seen[ST_OK], status_seen[ST_HEADER], status_seen[ST_SENDER],
             status_seen[ST_RECIP], status_seen[ST_ROUTE], status_seen[ST_SHORT]);
    $display("  compressed %0d signature %0d padding %0d", status_seen[ST_COMPRESSED],
             status_seen[ST_SIGNATURE], status_seen[ST_PADDING]);
    if (mismatches == 0 && tag_results_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// ----- mesh_packet_deframer_core.f -----
rtl/core/mpd_pkg.sv
rtl/core/mpd_parser.sv
rtl/core/mesh_packet_deframer_core.sv
dv/tb_mesh_packet_deframer_core.sv
